### sv/i2c_ras_pkg.sv
// ============================================================================
// I2C register access sequencer - shared definitions
// Status codes, item kinds, engine command codes, phase codes and result codes.
// ============================================================================
package i2c_ras_pkg;

    // masked engine status codes
    localparam logic [7:0] ST_START_OK  = 8'h08;
    localparam logic [7:0] ST_RSTART_OK = 8'h10;
    localparam logic [7:0] ST_SLAW_ACK  = 8'h18;
    localparam logic [7:0] ST_SLAR_ACK  = 8'h40;
    localparam logic [7:0] ST_DATA_ACK  = 8'h28;
    localparam logic [7:0] ST_MASK      = 8'hF8;
    localparam logic [7:0] TIMEOUT_BYTE = 8'hFF;

    localparam logic [15:0] WAIT_LIMIT_RESET = 16'd1000;

    // input item kinds
    localparam logic [1:0] MODE_WRITE = 2'd0;
    localparam logic [1:0] MODE_READ  = 2'd1;
    localparam logic [1:0] MODE_DONE  = 2'd2;
    localparam logic [1:0] MODE_TICK  = 2'd3;

    // engine commands
    localparam logic [2:0] ACT_NONE  = 3'd0;
    localparam logic [2:0] ACT_START = 3'd1;
    localparam logic [2:0] ACT_SEND  = 3'd2;
    localparam logic [2:0] ACT_READ  = 3'd3;
    localparam logic [2:0] ACT_STOP  = 3'd4;

    // result codes
    localparam logic [2:0] RC_OK      = 3'd0;
    localparam logic [2:0] RC_START   = 3'd1;
    localparam logic [2:0] RC_SLAW    = 3'd2;
    localparam logic [2:0] RC_REG     = 3'd3;
    localparam logic [2:0] RC_DATA    = 3'd4;
    localparam logic [2:0] RC_SLAR    = 3'd5;

    // sequencer phases
    localparam logic [3:0] PH_IDLE   = 4'd0;
    localparam logic [3:0] PH_START  = 4'd1;
    localparam logic [3:0] PH_SLAW   = 4'd2;
    localparam logic [3:0] PH_REG    = 4'd3;
    localparam logic [3:0] PH_DATA   = 4'd4;
    localparam logic [3:0] PH_RSTART = 4'd5;
    localparam logic [3:0] PH_SLAR   = 4'd6;
    localparam logic [3:0] PH_READ   = 4'd7;

    typedef struct packed {
        logic [1:0] mode;
        logic [6:0] dev_addr;
        logic [7:0] reg_addr;
        logic [7:0] wr_data;
        logic [7:0] bus_status;
        logic [7:0] rx_byte;
    } req_t;

    typedef struct packed {
        logic [2:0] action;
        logic [7:0] tx_byte;
        logic       finished;
        logic [2:0] result_code;
        logic [7:0] read_data;
    } rsp_t;

endpackage

### sv/i2c_ras_req_if.sv
// ============================================================================
// I2C register access sequencer - request channel
// Valid/ready channel carrying requests, engine completions and ticks.
// ============================================================================
interface i2c_ras_req_if;
    logic       valid;
    logic       ready;
    logic [1:0] mode;
    logic [6:0] dev_addr;
    logic [7:0] reg_addr;
    logic [7:0] wr_data;
    logic [7:0] bus_status;
    logic [7:0] rx_byte;

    modport source (
        output valid, mode, dev_addr, reg_addr, wr_data, bus_status, rx_byte,
        input  ready
    );
    modport sink (
        input  valid, mode, dev_addr, reg_addr, wr_data, bus_status, rx_byte,
        output ready
    );
endinterface

### sv/i2c_ras_rsp_if.sv
// ============================================================================
// I2C register access sequencer - result channel
// Valid/ready channel carrying engine commands and transaction outcome.
// ============================================================================
interface i2c_ras_rsp_if;
    logic       valid;
    logic       ready;
    logic [2:0] action;
    logic [7:0] tx_byte;
    logic       finished;
    logic [2:0] result_code;
    logic [7:0] read_data;

    modport source (
        output valid, action, tx_byte, finished, result_code, read_data,
        input  ready
    );
    modport sink (
        input  valid, action, tx_byte, finished, result_code, read_data,
        output ready
    );
endinterface

### sv/i2c_register_access_sequencer.sv
// ============================================================================
// I2C register access sequencer
// Runs one single-register write or read over a byte-level bus engine.
// ============================================================================
// Usage
//   req (sink): one item per handshake; mode selects write request, read
//     request, engine completion (masked status + received byte) or a tick.
//   rsp (source): exactly one result per accepted item - the next engine
//     command, and on the last step finished, result_code and read_data.
//   cfg_we / cfg_wdata: writes wait_limit, the tick count after which a
//     pending engine step counts as a timeout. Write only while idle.
// A result is registered and appears in the cycle after its item is accepted.
// Throughput: one item per cycle unless rsp.ready holds off a pending result;
//   the state update and result decode sit in a single combinational pass
//   between the phase register and the result register.
// Reset: phase returns to idle, wait_limit to 1000, result register empty.
// Stall: the result register holds while rsp.ready is low; req.ready stays
//   high while the result register is empty or being drained this cycle,
//   so a stalled receiver back-pressures the request side by one item.
// ============================================================================
module i2c_register_access_sequencer (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        cfg_we,
    input  logic [15:0] cfg_wdata,
    i2c_ras_req_if.sink   req,
    i2c_ras_rsp_if.source rsp
);

    // sequencer state
    logic [3:0]  phase_reg, phase_next;
    logic        is_read_reg, is_read_next;
    logic [6:0]  saved_dev_reg, saved_dev_next;
    logic [7:0]  saved_reg_reg, saved_reg_next;
    logic [7:0]  saved_wdata_reg, saved_wdata_next;
    logic [15:0] wait_count_reg, wait_count_next;
    logic [15:0] wait_limit_reg;

    // result register
    logic                  rsp_valid_reg;
    i2c_ras_pkg::rsp_t     rsp_reg, rsp_next;

    logic        accept;
    logic [15:0] count_inc;
    logic        timed_out;
    logic        do_advance;
    logic [7:0]  status;

    assign req.ready = !rsp_valid_reg || rsp.ready;
    assign accept    = req.valid && req.ready;

    // tick counting: a wrapped count also times out
    assign count_inc = wait_count_reg + 16'd1;
    assign timed_out = (count_inc >= wait_limit_reg) || (count_inc == 16'd0);

    assign do_advance = (req.mode == i2c_ras_pkg::MODE_DONE) ||
                        ((req.mode == i2c_ras_pkg::MODE_TICK) && timed_out);
    // a timeout presents a status that never matches an expected code
    assign status = (req.mode == i2c_ras_pkg::MODE_DONE)
                  ? (req.bus_status & i2c_ras_pkg::ST_MASK)
                  : i2c_ras_pkg::TIMEOUT_BYTE;

    always_comb
    begin
        phase_next       = phase_reg;
        is_read_next     = is_read_reg;
        saved_dev_next   = saved_dev_reg;
        saved_reg_next   = saved_reg_reg;
        saved_wdata_next = saved_wdata_reg;
        wait_count_next  = wait_count_reg;
        rsp_next         = '0;

        if (phase_reg == i2c_ras_pkg::PH_IDLE)
        begin
            // only requests start a transaction; anything else is ignored
            if ((req.mode == i2c_ras_pkg::MODE_WRITE) ||
                (req.mode == i2c_ras_pkg::MODE_READ))
            begin
                is_read_next     = (req.mode == i2c_ras_pkg::MODE_READ);
                saved_dev_next   = req.dev_addr;
                saved_reg_next   = req.reg_addr;
                saved_wdata_next = req.wr_data;
                phase_next       = i2c_ras_pkg::PH_START;
                wait_count_next  = '0;
                rsp_next.action  = i2c_ras_pkg::ACT_START;
            end
        end
        else
        begin
            if (req.mode == i2c_ras_pkg::MODE_TICK)
                wait_count_next = count_inc;

            if (do_advance)
            begin
                // defaults for a finishing step; issuing steps override
                phase_next = i2c_ras_pkg::PH_IDLE;
                case (phase_reg)
                    i2c_ras_pkg::PH_START:
                    begin
                        if (status != i2c_ras_pkg::ST_START_OK)
                        begin
                            rsp_next.finished    = 1'b1;
                            rsp_next.result_code = i2c_ras_pkg::RC_START;
                        end
                        else
                        begin
                            phase_next       = i2c_ras_pkg::PH_SLAW;
                            wait_count_next  = '0;
                            rsp_next.action  = i2c_ras_pkg::ACT_SEND;
                            rsp_next.tx_byte = {saved_dev_reg, 1'b0};
                        end
                    end
                    i2c_ras_pkg::PH_SLAW:
                    begin
                        if (status != i2c_ras_pkg::ST_SLAW_ACK)
                        begin
                            rsp_next.action      = i2c_ras_pkg::ACT_STOP;
                            rsp_next.finished    = 1'b1;
                            rsp_next.result_code = i2c_ras_pkg::RC_SLAW;
                        end
                        else
                        begin
                            phase_next       = i2c_ras_pkg::PH_REG;
                            wait_count_next  = '0;
                            rsp_next.action  = i2c_ras_pkg::ACT_SEND;
                            rsp_next.tx_byte = saved_reg_reg;
                        end
                    end
                    i2c_ras_pkg::PH_REG:
                    begin
                        if (status != i2c_ras_pkg::ST_DATA_ACK)
                        begin
                            rsp_next.finished    = 1'b1;
                            rsp_next.result_code = i2c_ras_pkg::RC_REG;
                        end
                        else if (is_read_reg)
                        begin
                            phase_next      = i2c_ras_pkg::PH_RSTART;
                            wait_count_next = '0;
                            rsp_next.action = i2c_ras_pkg::ACT_START;
                        end
                        else
                        begin
                            phase_next       = i2c_ras_pkg::PH_DATA;
                            wait_count_next  = '0;
                            rsp_next.action  = i2c_ras_pkg::ACT_SEND;
                            rsp_next.tx_byte = saved_wdata_reg;
                        end
                    end
                    i2c_ras_pkg::PH_DATA:
                    begin
                        rsp_next.finished = 1'b1;
                        if (status != i2c_ras_pkg::ST_DATA_ACK)
                            rsp_next.result_code = i2c_ras_pkg::RC_DATA;
                        else
                            rsp_next.action = i2c_ras_pkg::ACT_STOP;
                    end
                    i2c_ras_pkg::PH_RSTART:
                    begin
                        if (status != i2c_ras_pkg::ST_RSTART_OK)
                        begin
                            rsp_next.finished    = 1'b1;
                            rsp_next.result_code = i2c_ras_pkg::RC_DATA;
                        end
                        else
                        begin
                            phase_next       = i2c_ras_pkg::PH_SLAR;
                            wait_count_next  = '0;
                            rsp_next.action  = i2c_ras_pkg::ACT_SEND;
                            rsp_next.tx_byte = {saved_dev_reg, 1'b1};
                        end
                    end
                    i2c_ras_pkg::PH_SLAR:
                    begin
                        if (status != i2c_ras_pkg::ST_SLAR_ACK)
                        begin
                            rsp_next.action      = i2c_ras_pkg::ACT_STOP;
                            rsp_next.finished    = 1'b1;
                            rsp_next.result_code = i2c_ras_pkg::RC_SLAR;
                        end
                        else
                        begin
                            phase_next      = i2c_ras_pkg::PH_READ;
                            wait_count_next = '0;
                            rsp_next.action = i2c_ras_pkg::ACT_READ;
                        end
                    end
                    i2c_ras_pkg::PH_READ:
                    begin
                        // a timed-out read still ends cleanly with a stop
                        rsp_next.action    = i2c_ras_pkg::ACT_STOP;
                        rsp_next.finished  = 1'b1;
                        rsp_next.read_data = (req.mode == i2c_ras_pkg::MODE_DONE)
                                           ? req.rx_byte : i2c_ras_pkg::TIMEOUT_BYTE;
                    end
                    default:
                    begin
                        phase_next = i2c_ras_pkg::PH_IDLE;
                    end
                endcase
            end
        end
    end

    // control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg      <= i2c_ras_pkg::PH_IDLE;
            is_read_reg    <= 1'b0;
            wait_count_reg <= '0;
            wait_limit_reg <= i2c_ras_pkg::WAIT_LIMIT_RESET;
            rsp_valid_reg  <= 1'b0;
        end
        else
        begin
            if (cfg_we)
                wait_limit_reg <= cfg_wdata;
            if (accept)
            begin
                phase_reg      <= phase_next;
                is_read_reg    <= is_read_next;
                wait_count_reg <= wait_count_next;
                rsp_valid_reg  <= 1'b1;
            end
            else if (rsp.ready)
            begin
                rsp_valid_reg <= 1'b0;
            end
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            saved_dev_reg   <= saved_dev_next;
            saved_reg_reg   <= saved_reg_next;
            saved_wdata_reg <= saved_wdata_next;
            rsp_reg         <= rsp_next;
        end
    end

    assign rsp.valid       = rsp_valid_reg;
    assign rsp.action      = rsp_reg.action;
    assign rsp.tx_byte     = rsp_reg.tx_byte;
    assign rsp.finished    = rsp_reg.finished;
    assign rsp.result_code = rsp_reg.result_code;
    assign rsp.read_data   = rsp_reg.read_data;

    // ------------------------------------------------------------------------
    // Assertions
    // ------------------------------------------------------------------------
    a_accept_gives_result: assert property (
        @(posedge clk) disable iff (!rst_n)
        (req.valid && req.ready) |=> rsp.valid
    ) else $error("accepted item produced no result");

    a_code_only_when_done: assert property (
        @(posedge clk) disable iff (!rst_n)
        (rsp.valid && !rsp.finished) |-> (rsp.result_code == i2c_ras_pkg::RC_OK)
    ) else $error("result code without end of transaction");

    a_read_data_on_stop: assert property (
        @(posedge clk) disable iff (!rst_n)
        (rsp.valid && (rsp.read_data != 8'd0)) |->
            (rsp.finished && (rsp.action == i2c_ras_pkg::ACT_STOP))
    ) else $error("read data outside a finishing stop");

    a_finish_goes_idle: assert property (
        @(posedge clk) disable iff (!rst_n)
        (req.valid && req.ready) |=>
            (!rsp.finished || (phase_reg == i2c_ras_pkg::PH_IDLE))
    ) else $error("finished transaction left sequencer busy");

endmodule

### dv/tb_i2c_register_access_sequencer.sv
// ============================================================================
// I2C register access sequencer - testbench
// Drives requests, engine completions and ticks into the sequencer and
// checks every engine command and outcome against a cycle-free predictor.
// Short directed tests come first, then random well-formed transactions with
// injected status failures, timeouts and noise, under several wait limits.
// ============================================================================
module tb_i2c_register_access_sequencer;
    timeunit 1ns;
    timeprecision 1ps;

    logic        clk;
    logic        rst_n;
    logic        cfg_we;
    logic [15:0] cfg_wdata;

    i2c_ras_req_if req_ch ();
    i2c_ras_rsp_if rsp_ch ();

    i2c_register_access_sequencer dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_wdata (cfg_wdata),
        .req       (req_ch),
        .rsp       (rsp_ch)
    );

    // ------------------------------------------------------------------------
    // Predictor state: a private copy of the sequencer's registers
    // ------------------------------------------------------------------------
    logic [15:0] lim_q;        // wait_limit as last written
    logic [3:0]  seq_phase;
    logic        rd_q;         // current transaction is a register read
    logic [6:0]  dev_q;
    logic [7:0]  reg_q;
    logic [7:0]  wdata_q;
    logic [15:0] ticks_q;      // ticks seen in the stage now waiting
    logic [2:0]  last_code;
    logic [7:0]  last_rx;

    i2c_ras_pkg::rsp_t engine_cmd_q[$];     // predicted results, oldest first
    int   mismatches;
    int   live_items;          // accepted items that the block acted on
    int   idle_style;          // 0 no gaps, 1 full random gaps, 2 rare gaps

    // ------------------------------------------------------------------------
    // Clock, and a hard stop in case the run hangs
    // ------------------------------------------------------------------------
    initial
    begin
        clk = 1'b0;
        forever #2 clk = ~clk;
    end

    initial
    begin
        #2_000_000;
        $display("tb_i2c_register_access_sequencer: done, errors");
        $finish;
    end

    // ------------------------------------------------------------------------
    // Predictor
    // ------------------------------------------------------------------------
    function automatic i2c_ras_pkg::rsp_t cmd(input logic [2:0] act,
                                              input logic [7:0] tx,
                                              input logic fin, input logic [2:0] code,
                                              input logic [7:0] rd);
        i2c_ras_pkg::rsp_t r;
        r.action      = act;
        r.tx_byte     = tx;
        r.finished    = fin;
        r.result_code = code;
        r.read_data   = rd;
        return r;
    endfunction

    // Transaction ends; a stop goes out only where the sequence calls for one
    function automatic i2c_ras_pkg::rsp_t end_xfer(input logic with_stop,
                                                   input logic [2:0] code,
                                                   input logic [7:0] rd);
        last_code = code;
        seq_phase = i2c_ras_pkg::PH_IDLE;
        return cmd(with_stop ? i2c_ras_pkg::ACT_STOP : i2c_ras_pkg::ACT_NONE,
                   8'h00, 1'b1, code, rd);
    endfunction

    // Next engine command; the tick count restarts for the new stage
    function automatic i2c_ras_pkg::rsp_t next_stage(input logic [3:0] nxt,
                                                     input logic [2:0] act,
                                                     input logic [7:0] tx);
        seq_phase = nxt;
        ticks_q   = '0;
        return cmd(act, tx, 1'b0, i2c_ras_pkg::RC_OK, 8'h00);
    endfunction

    // Completion (or timeout) of the stage now waiting; st is the masked status
    function automatic i2c_ras_pkg::rsp_t stage_done(input logic [7:0] st,
                                                     input logic timed_out,
                                                     input logic [7:0] rx);
        case (seq_phase)
            i2c_ras_pkg::PH_START:
            begin
                if (st != i2c_ras_pkg::ST_START_OK)
                    return end_xfer(1'b0, i2c_ras_pkg::RC_START, 8'h00);
                return next_stage(i2c_ras_pkg::PH_SLAW, i2c_ras_pkg::ACT_SEND,
                                  {dev_q, 1'b0});
            end
            i2c_ras_pkg::PH_SLAW:
            begin
                if (st != i2c_ras_pkg::ST_SLAW_ACK)
                    return end_xfer(1'b1, i2c_ras_pkg::RC_SLAW, 8'h00);
                return next_stage(i2c_ras_pkg::PH_REG, i2c_ras_pkg::ACT_SEND, reg_q);
            end
            i2c_ras_pkg::PH_REG:
            begin
                if (st != i2c_ras_pkg::ST_DATA_ACK)
                    return end_xfer(1'b0, i2c_ras_pkg::RC_REG, 8'h00);
                if (rd_q)
                    return next_stage(i2c_ras_pkg::PH_RSTART, i2c_ras_pkg::ACT_START,
                                      8'h00);
                return next_stage(i2c_ras_pkg::PH_DATA, i2c_ras_pkg::ACT_SEND, wdata_q);
            end
            i2c_ras_pkg::PH_DATA:
            begin
                if (st != i2c_ras_pkg::ST_DATA_ACK)
                    return end_xfer(1'b0, i2c_ras_pkg::RC_DATA, 8'h00);
                return end_xfer(1'b1, i2c_ras_pkg::RC_OK, 8'h00);
            end
            i2c_ras_pkg::PH_RSTART:
            begin
                if (st != i2c_ras_pkg::ST_RSTART_OK)
                    return end_xfer(1'b0, i2c_ras_pkg::RC_DATA, 8'h00);
                return next_stage(i2c_ras_pkg::PH_SLAR, i2c_ras_pkg::ACT_SEND,
                                  {dev_q, 1'b1});
            end
            i2c_ras_pkg::PH_SLAR:
            begin
                if (st != i2c_ras_pkg::ST_SLAR_ACK)
                    return end_xfer(1'b1, i2c_ras_pkg::RC_SLAR, 8'h00);
                return next_stage(i2c_ras_pkg::PH_READ, i2c_ras_pkg::ACT_READ, 8'h00);
            end
            i2c_ras_pkg::PH_READ:
            begin
                // a timed-out read still succeeds, with the all-ones byte
                last_rx = timed_out ? i2c_ras_pkg::TIMEOUT_BYTE : rx;
                return end_xfer(1'b1, i2c_ras_pkg::RC_OK, last_rx);
            end
            default:
            begin
                seq_phase = i2c_ras_pkg::PH_IDLE;
                return cmd(i2c_ras_pkg::ACT_NONE, 8'h00, 1'b0, i2c_ras_pkg::RC_OK, 8'h00);
            end
        endcase
    endfunction

    function automatic i2c_ras_pkg::rsp_t sequencer_step(input i2c_ras_pkg::req_t it);
        if (seq_phase == i2c_ras_pkg::PH_IDLE)
        begin
            if (it.mode == i2c_ras_pkg::MODE_WRITE || it.mode == i2c_ras_pkg::MODE_READ)
            begin
                rd_q    = (it.mode == i2c_ras_pkg::MODE_READ);
                dev_q   = it.dev_addr;
                reg_q   = it.reg_addr;
                wdata_q = it.wr_data;
                return next_stage(i2c_ras_pkg::PH_START, i2c_ras_pkg::ACT_START, 8'h00);
            end
            return cmd(i2c_ras_pkg::ACT_NONE, 8'h00, 1'b0, i2c_ras_pkg::RC_OK, 8'h00);
        end
        if (it.mode == i2c_ras_pkg::MODE_DONE)
            return stage_done(it.bus_status & i2c_ras_pkg::ST_MASK, 1'b0, it.rx_byte);
        if (it.mode == i2c_ras_pkg::MODE_TICK)
        begin
            ticks_q = ticks_q + 16'd1;
            if (ticks_q >= lim_q || ticks_q == 16'd0)
                return stage_done(i2c_ras_pkg::TIMEOUT_BYTE, 1'b1, 8'h00);
        end
        return cmd(i2c_ras_pkg::ACT_NONE, 8'h00, 1'b0, i2c_ras_pkg::RC_OK, 8'h00);
    endfunction

    // ------------------------------------------------------------------------
    // Stimulus helpers
    // ------------------------------------------------------------------------
    function automatic int pick_gap();
        case (idle_style)
            0:       return 0;
            1:       return $urandom_range(0, 13);
            default: return ($urandom_range(0, 3) == 0) ? $urandom_range(1, 13) : 0;
        endcase
    endfunction

    function automatic i2c_ras_pkg::req_t mk_item(input logic [1:0] m, input logic [6:0] d,
                                                  input logic [7:0] r, input logic [7:0] w,
                                                  input logic [7:0] s, input logic [7:0] x);
        i2c_ras_pkg::req_t it;
        it.mode       = m;
        it.dev_addr   = d;
        it.reg_addr   = r;
        it.wr_data    = w;
        it.bus_status = s;
        it.rx_byte    = x;
        return it;
    endfunction

    function automatic i2c_ras_pkg::req_t rand_item(input logic [1:0] m);
        return mk_item(m, 7'($urandom), 8'($urandom), 8'($urandom),
                       8'($urandom), 8'($urandom));
    endfunction

    // Status that lets the waiting stage proceed; the byte read accepts any
    function automatic logic [7:0] good_status(input logic [3:0] ph);
        case (ph)
            i2c_ras_pkg::PH_START:  return i2c_ras_pkg::ST_START_OK;
            i2c_ras_pkg::PH_SLAW:   return i2c_ras_pkg::ST_SLAW_ACK;
            i2c_ras_pkg::PH_REG:    return i2c_ras_pkg::ST_DATA_ACK;
            i2c_ras_pkg::PH_DATA:   return i2c_ras_pkg::ST_DATA_ACK;
            i2c_ras_pkg::PH_RSTART: return i2c_ras_pkg::ST_RSTART_OK;
            i2c_ras_pkg::PH_SLAR:   return i2c_ras_pkg::ST_SLAR_ACK;
            default:                return 8'h00;
        endcase
    endfunction

    // One transaction on the request channel; the prediction is taken at the
    // accepting edge so the generator always sees the up-to-date phase.
    // Valid is left high after acceptance and only lowered at the next
    // falling edge if a gap follows.
    task automatic send_item(input i2c_ras_pkg::req_t it);
        int   gap;
        logic ignored;
        gap = pick_gap();
        @(negedge clk);
        if (gap > 0)
        begin
            req_ch.valid <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        req_ch.valid      <= 1'b1;
        req_ch.mode       <= it.mode;
        req_ch.dev_addr   <= it.dev_addr;
        req_ch.reg_addr   <= it.reg_addr;
        req_ch.wr_data    <= it.wr_data;
        req_ch.bus_status <= it.bus_status;
        req_ch.rx_byte    <= it.rx_byte;
        do @(posedge clk); while (req_ch.ready !== 1'b1);
        ignored = (seq_phase == i2c_ras_pkg::PH_IDLE)
                ? (it.mode == i2c_ras_pkg::MODE_DONE || it.mode == i2c_ras_pkg::MODE_TICK)
                : (it.mode == i2c_ras_pkg::MODE_WRITE || it.mode == i2c_ras_pkg::MODE_READ);
        if (!ignored)
            live_items++;
        engine_cmd_q.push_back(sequencer_step(it));
    endtask

    // Drop valid and wait until every predicted result has been taken
    task automatic settle();
        @(negedge clk);
        req_ch.valid <= 1'b0;
        while (engine_cmd_q.size() != 0) @(posedge clk);
    endtask

    // wait_limit may only change while the sequencer is idle: any open
    // transaction is ended by an all-zero completion first
    task automatic set_wait_limit(input logic [15:0] v);
        while (seq_phase != i2c_ras_pkg::PH_IDLE)
            send_item(mk_item(i2c_ras_pkg::MODE_DONE, 7'h00, 8'h00, 8'h00, 8'h00, 8'h00));
        settle();
        repeat (2) @(negedge clk);
        cfg_we    <= 1'b1;
        cfg_wdata <= v;
        @(negedge clk);
        cfg_we    <= 1'b0;
        lim_q = v;
    endtask

    task automatic report_mismatch(input string msg);
        $display("[%0t] mismatch: %s", $realtime, msg);
        mismatches++;
    endtask

    // ------------------------------------------------------------------------
    // Result side: random stalls, then compare against the oldest prediction
    // ------------------------------------------------------------------------
    initial
    begin
        i2c_ras_pkg::rsp_t got;
        i2c_ras_pkg::rsp_t want;
        int   gap;
        rsp_ch.ready = 1'b0;
        forever
        begin
            @(negedge clk);
            gap = pick_gap();
            if (gap > 0)
            begin
                rsp_ch.ready <= 1'b0;
                repeat (gap) @(negedge clk);
            end
            rsp_ch.ready <= 1'b1;
            do @(posedge clk); while (rsp_ch.valid !== 1'b1);
            got = cmd(rsp_ch.action, rsp_ch.tx_byte, rsp_ch.finished,
                      rsp_ch.result_code, rsp_ch.read_data);
            if (engine_cmd_q.size() == 0)
                report_mismatch($sformatf("result %p with nothing predicted", got));
            else
            begin
                want = engine_cmd_q.pop_front();
                if (got.action !== want.action)
                    report_mismatch($sformatf("action %0d, predicted %0d",
                                              got.action, want.action));
                if (got.tx_byte !== want.tx_byte)
                    report_mismatch($sformatf("tx_byte %h, predicted %h",
                                              got.tx_byte, want.tx_byte));
                if (got.finished !== want.finished)
                    report_mismatch($sformatf("finished %0d, predicted %0d",
                                              got.finished, want.finished));
                if (got.result_code !== want.result_code)
                    report_mismatch($sformatf("result_code %0d, predicted %0d",
                                              got.result_code, want.result_code));
                if (got.read_data !== want.read_data)
                    report_mismatch($sformatf("read_data %h, predicted %h",
                                              got.read_data, want.read_data));
            end
        end
    end

    // ------------------------------------------------------------------------
    // Tests
    // ------------------------------------------------------------------------

    // Completions and ticks are ignored while no transaction is open
    task automatic test_ignored_when_idle();
        send_item(mk_item(i2c_ras_pkg::MODE_DONE, 7'h7F, 8'hFF, 8'hFF,
                          i2c_ras_pkg::ST_START_OK, 8'hFF));
        send_item(mk_item(i2c_ras_pkg::MODE_TICK, 7'h00, 8'h00, 8'h00, 8'h00, 8'h00));
    endtask

    // Full write with all-ones fields; the first three statuses carry junk in the masked bits
    // and a read request arrives mid-transaction and must be ignored
    task automatic test_write_max_fields();
        send_item(mk_item(i2c_ras_pkg::MODE_WRITE, 7'h7F, 8'hFF, 8'hFF, 8'h00, 8'h00));
        send_item(mk_item(i2c_ras_pkg::MODE_READ, 7'h00, 8'h00, 8'h00, 8'h00, 8'h00));
        send_item(mk_item(i2c_ras_pkg::MODE_DONE, 7'h00, 8'h00, 8'h00,
                          i2c_ras_pkg::ST_START_OK | 8'h07, 8'h00));
        send_item(mk_item(i2c_ras_pkg::MODE_DONE, 7'h7F, 8'hFF, 8'hFF,
                          i2c_ras_pkg::ST_SLAW_ACK | 8'h07, 8'hFF));
        send_item(mk_item(i2c_ras_pkg::MODE_DONE, 7'h00, 8'h00, 8'h00,
                          i2c_ras_pkg::ST_DATA_ACK | 8'h07, 8'h00));
        send_item(mk_item(i2c_ras_pkg::MODE_DONE, 7'h00, 8'h00, 8'h00,
                          i2c_ras_pkg::ST_DATA_ACK, 8'h00));
    endtask

    // Full read with all-zero fields; one tick under the reset limit
    task automatic test_read_zero_fields();
        send_item(mk_item(i2c_ras_pkg::MODE_READ, 7'h00, 8'h00, 8'h00, 8'h00, 8'h00));
        send_item(mk_item(i2c_ras_pkg::MODE_TICK, 7'h00, 8'h00, 8'h00, 8'h00, 8'h00));
        send_item(mk_item(i2c_ras_pkg::MODE_DONE, 7'h00, 8'h00, 8'h00,
                          i2c_ras_pkg::ST_START_OK, 8'h00));
        send_item(mk_item(i2c_ras_pkg::MODE_DONE, 7'h00, 8'h00, 8'h00,
                          i2c_ras_pkg::ST_SLAW_ACK, 8'h00));
        send_item(mk_item(i2c_ras_pkg::MODE_DONE, 7'h00, 8'h00, 8'h00,
                          i2c_ras_pkg::ST_DATA_ACK, 8'h00));
        send_item(mk_item(i2c_ras_pkg::MODE_DONE, 7'h00, 8'h00, 8'h00,
                          i2c_ras_pkg::ST_RSTART_OK, 8'h00));
        send_item(mk_item(i2c_ras_pkg::MODE_DONE, 7'h00, 8'h00, 8'h00,
                          i2c_ras_pkg::ST_SLAR_ACK, 8'h00));
        send_item(mk_item(i2c_ras_pkg::MODE_DONE, 7'h00, 8'h00, 8'h00, 8'h00, 8'hA5));
    endtask

    // With a wait limit of 1, a tick during the byte read times out:
    // the transaction still succeeds, with a stop and the all-ones byte
    task automatic test_read_timeout();
        set_wait_limit(16'd1);
        send_item(mk_item(i2c_ras_pkg::MODE_READ, 7'h55, 8'hAA, 8'h55, 8'h00, 8'h00));
        send_item(mk_item(i2c_ras_pkg::MODE_DONE, 7'h00, 8'h00, 8'h00,
                          i2c_ras_pkg::ST_START_OK, 8'h00));
        send_item(mk_item(i2c_ras_pkg::MODE_DONE, 7'h00, 8'h00, 8'h00,
                          i2c_ras_pkg::ST_SLAW_ACK, 8'h00));
        send_item(mk_item(i2c_ras_pkg::MODE_DONE, 7'h00, 8'h00, 8'h00,
                          i2c_ras_pkg::ST_DATA_ACK, 8'h00));
        send_item(mk_item(i2c_ras_pkg::MODE_DONE, 7'h00, 8'h00, 8'h00,
                          i2c_ras_pkg::ST_RSTART_OK, 8'h00));
        send_item(mk_item(i2c_ras_pkg::MODE_DONE, 7'h00, 8'h00, 8'h00,
                          i2c_ras_pkg::ST_SLAR_ACK, 8'h00));
        send_item(mk_item(i2c_ras_pkg::MODE_TICK, 7'h00, 8'h00, 8'h00, 8'h00, 8'h00));
    endtask

    // One transaction with random content: ticks before some completions
    // (enough to time out when the limit is small), an occasional stray
    // request or random item, and a failing status at bad_pct percent
    task automatic run_random_xfer(input int bad_pct);
        int                int_n;
        int                tick_cap;
        i2c_ras_pkg::req_t it;
        logic [7:0]        good;
        tick_cap = (lim_q <= 16'd20) ? int'(lim_q) + 1 : 3;
        send_item(rand_item($urandom_range(0, 1) ? i2c_ras_pkg::MODE_READ
                                                 : i2c_ras_pkg::MODE_WRITE));
        while (seq_phase != i2c_ras_pkg::PH_IDLE)
        begin
            int_n = ($urandom_range(0, 2) == 0) ? $urandom_range(1, tick_cap) : 0;
            repeat (int_n)
                if (seq_phase != i2c_ras_pkg::PH_IDLE)
                    send_item(rand_item(i2c_ras_pkg::MODE_TICK));
            if (seq_phase == i2c_ras_pkg::PH_IDLE)
                break;
            if ($urandom_range(0, 15) == 0)
                send_item(rand_item(2'($urandom)));
            if (seq_phase == i2c_ras_pkg::PH_IDLE)
                break;
            good = good_status(seq_phase);
            it   = rand_item(i2c_ras_pkg::MODE_DONE);
            if ($urandom_range(0, 99) >= bad_pct)
                it.bus_status = good | 8'($urandom_range(0, 7));
            else
                while ((it.bus_status & i2c_ras_pkg::ST_MASK) == good)
                    it.bus_status = 8'($urandom);
            send_item(it);
        end
    endtask

    // Several limit settings, extremes included; the phases take three gap styles in
    // turn so stalls land on every stage, with some gap-free stretches
    task automatic test_random_traffic();
        logic [15:0] limits[8];
        int          target;
        limits = '{16'd1, 16'd65535, 16'd2, 16'd1000, 16'd3, 16'd0, 16'd5, 16'd0};
        for (int p = 0; p < 8; p++)
        begin
            set_wait_limit((limits[p] == 16'd0) ? 16'($urandom_range(1, 20)) : limits[p]);
            idle_style = p % 3;
            target     = live_items + 200;
            while (live_items < target)
            begin
                // noise between transactions: idle completions, ticks or
                // requests that open a transaction left for the next pass
                if ($urandom_range(0, 3) == 0)
                    repeat ($urandom_range(1, 3)) send_item(rand_item(2'($urandom)));
                run_random_xfer(8);
            end
        end
    endtask

    // ------------------------------------------------------------------------
    // Main sequence
    // ------------------------------------------------------------------------
    initial
    begin
        rst_n             = 1'b0;
        cfg_we            = 1'b0;
        cfg_wdata         = '0;
        req_ch.valid      = 1'b0;
        req_ch.mode       = i2c_ras_pkg::MODE_WRITE;
        req_ch.dev_addr   = '0;
        req_ch.reg_addr   = '0;
        req_ch.wr_data    = '0;
        req_ch.bus_status = '0;
        req_ch.rx_byte    = '0;

        lim_q      = i2c_ras_pkg::WAIT_LIMIT_RESET;
        seq_phase  = i2c_ras_pkg::PH_IDLE;
        rd_q       = 1'b0;
        dev_q      = '0;
        reg_q      = '0;
        wdata_q    = '0;
        ticks_q    = '0;
        last_code  = i2c_ras_pkg::RC_OK;
        last_rx    = '0;
        mismatches = 0;
        live_items = 0;
        idle_style = 1;

        repeat (8) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        test_ignored_when_idle();
        test_write_max_fields();
        test_read_zero_fields();
        test_read_timeout();
        test_random_traffic();

        // drain, then allow time for anything unpredicted to show up
        settle();
        repeat (4) @(posedge clk);
        if (mismatches == 0)
            $display("tb_i2c_register_access_sequencer: done, clean");
        else
            $display("tb_i2c_register_access_sequencer: done, errors");
        $finish;
    end

endmodule
